// ===== rtl/core/ssvsd_pkg.sv =====
// Shared types, codes and constants of the optical sync-signature detector.
package ssvsd_pkg;

  // Item kinds carried in the input tuser
  localparam logic [1:0] OP_POLL       = 2'd0;
  localparam logic [1:0] OP_SRC_CHANGE = 2'd1;
  localparam logic [1:0] OP_PRESET     = 2'd2;
  localparam logic [1:0] OP_INVALIDATE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_RISE_THR = 2'd1;
  localparam logic [1:0] REG_FALL_THR = 2'd2;

  // Signature bytes and field masks
  localparam logic [7:0] SIG_C_BYTE  = 8'h8A;
  localparam logic [7:0] SIG_B_BYTE  = 8'h04;
  localparam logic [3:0] SIG_NIBBLE  = 4'hF;
  localparam logic [7:0] NEVER_SEEN  = 8'hFF;
  localparam logic [7:0] STREAK_MAX  = 8'hFF;
  localparam logic [6:0] VOL_CLAMP   = 7'd100;
  localparam int         VOL_MAX     = 100;
  localparam int         VOL_HALF    = 50;

  // Register reset values
  localparam logic [7:0] RISE_THR_RST = 8'd3;
  localparam logic [7:0] FALL_THR_RST = 8'd10;

  // Stream widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;
  localparam int QUEUE_DEPTH = 2;

  // Volume to index lookup, 0..100
  typedef logic [6:0] idx_tab_t [0:VOL_MAX];

  // Classified request handed from the front to the back
  typedef struct packed {
    logic [1:0] op;
    logic       sel;
    logic       locked;
    logic       hit;
    logic       mute;
    logic [6:0] vol;
    logic [6:0] idx;
    logic [6:0] db;
    logic       umute;
  } item_t;

  // Result fields, first field in the top bits
  typedef struct packed {
    logic       seen_mute;
    logic [7:0] seen_volume;
    logic       mute_value;
    logic       mute_write;
    logic [6:0] volume_db;
    logic       volume_write;
    logic       present_changed;
    logic       present;
  } result_t;

  // Build the scaled index table at elaboration, round half up
  function automatic idx_tab_t build_idx_tab(input int center);
    idx_tab_t tab;
    int       q;
    for (int v = 0; v <= VOL_MAX; v++) begin
      q = (v * center + VOL_HALF) / VOL_MAX;
      if (q > center) q = center;
      tab[v] = 7'(q);
    end
    return tab;
  endfunction

endpackage

// ===== rtl/core/spdif_status_volume_sync_detector_unit.sv =====
// Top level of the optical sync-signature detector with volume and mute follow.
// Throughput: one request per cycle unless the output stalls; the front classifies
// combinationally and the back updates the detector state and output register as it
// pops the head of a two-entry queue between them.
// Reset: synchronous, active high; clears state, queue and output, loads register
// defaults (disabled, rise threshold 3, fall threshold 10), volume never seen.
module spdif_status_volume_sync_detector_unit import ssvsd_pkg::*; #(
  parameter int CENTER_INDEX = 60
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // spdif_selected, cs_locked, cs_byte_5, cs_byte_6, cs_byte_7, cs_byte_8,
  // cs_byte_15, cs_byte_16, cs_byte_17, cs_byte_18, user_mute_now, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // present, present_changed, volume_write, volume_db, mute_write, mute_value,
  // last volume seen, last mute seen, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  item_t   front_item;
  item_t   head_item;
  logic    q_full;
  logic    q_not_empty;
  logic    q_pop;
  logic    push;
  result_t res;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  ssvsd_front #(
    .CENTER_INDEX(CENTER_INDEX)
  ) u_front (
    .op   (s_axis_tuser),
    .data (s_axis_tdata),
    .item (front_item)
  );

  ssvsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  ssvsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (q_not_empty),
    .in_item   (head_item),
    .in_pop    (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res};

endmodule

// ===== rtl/core/ssvsd_front.sv =====
// Front end: unpacks a request, checks both signature layouts and scales the volume.
module ssvsd_front import ssvsd_pkg::*; #(
  parameter int CENTER_INDEX = 60
) (
  input  logic [1:0]           op,
  input  logic [IN_DATA_W-1:0] data,
  output item_t                item
);

  localparam idx_tab_t   IdxTab    = build_idx_tab(CENTER_INDEX);
  localparam logic [6:0] CenterIdx = 7'(CENTER_INDEX);

  logic [7:0] b5, b6, b7, b8, b15, b16, b17, b18;
  logic       new_hit, old_hit;
  logic [7:0] vbyte;
  logic [6:0] vol;
  logic [6:0] idx;

  // Unpack the channel-status bytes
  assign b5  = data[9:2];
  assign b6  = data[17:10];
  assign b7  = data[25:18];
  assign b8  = data[33:26];
  assign b15 = data[41:34];
  assign b16 = data[49:42];
  assign b17 = data[57:50];
  assign b18 = data[65:58];

  // Newer layout takes precedence over the older one
  assign new_hit = (b16[3:0] == SIG_NIBBLE) && (b17 == SIG_B_BYTE) && (b18 == SIG_C_BYTE);
  assign old_hit = (b7[3:0] == SIG_NIBBLE) && (b6 == SIG_B_BYTE) && (b5 == SIG_C_BYTE);

  always_comb begin
    if (new_hit) begin
      vbyte = {b15[3:0], b16[7:4]};
    end else if (old_hit) begin
      vbyte = {b8[3:0], b7[7:4]};
    end else begin
      vbyte = 8'd0;
    end
  end

  // Clamp and scale the volume
  assign vol = (vbyte[6:0] > VOL_CLAMP) ? VOL_CLAMP : vbyte[6:0];
  assign idx = IdxTab[vol];

  always_comb begin
    item.op     = op;
    item.sel    = data[0];
    item.locked = data[1];
    item.hit    = new_hit || old_hit;
    item.mute   = vbyte[7];
    item.vol    = vol;
    item.idx    = idx;
    item.db     = idx - CenterIdx;
    item.umute  = data[66];
  end

endmodule

// ===== rtl/core/ssvsd_queue.sv =====
// Short queue of classified requests between the front and back ends.
module ssvsd_queue import ssvsd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ssvsd_back.sv =====
// Back end: hysteresis, volume cache, mute ownership and the output register.
module ssvsd_back import ssvsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  item_t      in_item,
  output logic       in_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  // Configuration
  logic       enable;
  logic [7:0] rise_thr;
  logic [7:0] fall_thr;

  // Detector state
  logic       present_flag, present_flag_next;
  logic [7:0] rise_streak, rise_streak_next;
  logic [7:0] fall_streak, fall_streak_next;
  logic [7:0] seen_volume, seen_volume_next;
  logic       seen_mute, seen_mute_next;
  logic       cache_valid, cache_valid_next;
  logic [6:0] cached_index, cached_index_next;
  logic       mute_owned, mute_owned_next;

  logic       demote_req;
  logic       promote_req;
  logic       miss;
  logic [7:0] rise_inc;
  logic [7:0] fall_inc;
  result_t    res;

  assign in_pop = in_valid && (!out_valid || out_ready);

  assign rise_inc = (rise_streak == STREAK_MAX) ? rise_streak : rise_streak + 8'd1;
  assign fall_inc = (fall_streak == STREAK_MAX) ? fall_streak : fall_streak + 8'd1;

  // Work out the next state and the result of the head request
  always_comb begin
    present_flag_next = present_flag;
    rise_streak_next  = rise_streak;
    fall_streak_next  = fall_streak;
    seen_volume_next  = seen_volume;
    seen_mute_next    = seen_mute;
    cache_valid_next  = cache_valid;
    cached_index_next = cached_index;
    mute_owned_next   = mute_owned;
    demote_req        = 1'b0;
    promote_req       = 1'b0;
    miss              = 1'b0;
    res               = '0;

    case (in_item.op)
      OP_POLL: begin
        if (!enable || !in_item.sel) begin
          demote_req = 1'b1;
        end else if (!in_item.locked || !in_item.hit) begin
          miss = 1'b1;
        end else begin
          fall_streak_next = 8'd0;
          rise_streak_next = rise_inc;
          promote_req      = present_flag || (rise_inc >= rise_thr);
        end
      end
      OP_SRC_CHANGE: begin
        if (!in_item.sel) begin
          demote_req = 1'b1;
        end else begin
          rise_streak_next = 8'd0;
          fall_streak_next = 8'd0;
        end
      end
      OP_PRESET: begin
        rise_streak_next = 8'd0;
        fall_streak_next = 8'd0;
        cache_valid_next = 1'b0;
        demote_req       = !enable;
      end
      OP_INVALIDATE: begin
        cache_valid_next = 1'b0;
      end
      default: begin
        cache_valid_next = cache_valid;
      end
    endcase

    // Count a miss and demote once the fall run is long enough
    if (miss) begin
      rise_streak_next = 8'd0;
      fall_streak_next = fall_inc;
      demote_req       = fall_inc >= fall_thr;
    end

    // Drop to absent, releasing a mute this block imposed
    if (demote_req && present_flag) begin
      present_flag_next   = 1'b0;
      rise_streak_next    = 8'd0;
      cache_valid_next    = 1'b0;
      mute_owned_next     = 1'b0;
      res.present_changed = 1'b1;
      if (mute_owned && in_item.umute) begin
        res.mute_write = 1'b1;
        res.mute_value = 1'b0;
      end
    end

    // Follow the decoded volume and mute
    if (promote_req) begin
      res.present_changed = !present_flag;
      present_flag_next   = 1'b1;
      if (!cache_valid || (in_item.idx != cached_index)) begin
        res.volume_write  = 1'b1;
        res.volume_db     = in_item.db;
        cached_index_next = in_item.idx;
        cache_valid_next  = 1'b1;
      end
      if (in_item.mute != in_item.umute) begin
        res.mute_write  = 1'b1;
        res.mute_value  = in_item.mute;
        mute_owned_next = in_item.mute;
      end
      seen_volume_next = {1'b0, in_item.vol};
      seen_mute_next   = in_item.mute;
    end

    res.present     = present_flag_next;
    res.seen_volume = seen_volume_next;
    res.seen_mute   = seen_mute_next;
  end

  // Hold the state and apply configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      rise_thr     <= RISE_THR_RST;
      fall_thr     <= FALL_THR_RST;
      present_flag <= 1'b0;
      rise_streak  <= 8'd0;
      fall_streak  <= 8'd0;
      seen_volume  <= NEVER_SEEN;
      seen_mute    <= 1'b0;
      cache_valid  <= 1'b0;
      cached_index <= 7'd0;
      mute_owned   <= 1'b0;
    end else begin
      if (in_pop) begin
        present_flag <= present_flag_next;
        rise_streak  <= rise_streak_next;
        fall_streak  <= fall_streak_next;
        seen_volume  <= seen_volume_next;
        seen_mute    <= seen_mute_next;
        cache_valid  <= cache_valid_next;
        cached_index <= cached_index_next;
        mute_owned   <= mute_owned_next;
      end
      if (cfg_wen) begin
        case (cfg_index)
          REG_ENABLE: begin
            if (cfg_wdata[0] != enable) begin
              rise_streak <= 8'd0;
              fall_streak <= 8'd0;
              cache_valid <= 1'b0;
            end
            enable <= cfg_wdata[0];
          end
          REG_RISE_THR: rise_thr <= cfg_wdata;
          REG_FALL_THR: fall_thr <= cfg_wdata;
          default: begin
            enable <= enable;
          end
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      out_res <= res;
    end
  end

endmodule
